FILE: hdl/escd_pkg.sv
// ----------------------------------------------------------------------------
// escd_pkg: shared types and constants for the epoch to civil converter
// Stage numbering, pipeline control bundle and the scaled reciprocals that
// stand in for the constant divisions.
// ----------------------------------------------------------------------------
`default_nettype none

package escd_pkg;

  localparam int NumStages = 10;
  localparam int PendW     = $clog2(NumStages + 1);

  // register stage indices
  localparam int StgClamp  = 0;
  localparam int StgDivEst = 1;
  localparam int StgDayFix = 2;
  localparam int StgEra    = 3;
  localparam int StgDoe    = 4;
  localparam int StgYoeArg = 5;
  localparam int StgYoe    = 6;
  localparam int StgDoy    = 7;
  localparam int StgMonth  = 8;
  localparam int StgOut    = 9;

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } pipe_ctrl_t;

  // 86400 = 675 * 2^7
  localparam int          DayLoBits   = 7;
  localparam logic [31:0] DayHi       = 32'd675;
  localparam logic [22:0] DayShift    = 23'd719468;
  localparam logic [22:0] DaysPerEra  = 23'd146097;
  localparam logic [17:0] DoeLast     = 18'd146096;
  localparam logic [17:0] DoeCent1    = 18'd36524;
  localparam logic [17:0] DoeCent2    = 18'd73048;
  localparam logic [17:0] DoeCent3    = 18'd109572;
  localparam logic [16:0] SecsPerHour = 17'd3600;

  // floor(2^41/675): quotient estimate low by at most one
  localparam logic [31:0] RecipDayHi = 32'((64'd1 << 41) / 64'd675);
  // rounded-up reciprocals, exact over the operand range in use
  localparam logic [23:0] RecipEra  = 24'(((64'd1 << 41) + 64'd146096) / 64'd146097);
  localparam logic [18:0] Recip1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] Recip365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  Recip100  = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] Recip153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [11:0] Recip5    = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
  localparam logic [17:0] Recip3600 = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] Recip60   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

endpackage

`default_nettype wire

FILE: hdl/escd_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// escd_pipe_ctrl: stage valids and enables
// Each stage advances when it is empty or the next one advances, so bubbles
// close up while the output beat is held.
// ----------------------------------------------------------------------------
`default_nettype none

module escd_pipe_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output escd_pkg::pipe_ctrl_t    ctrl_o,
  output logic                    in_ready_o,
  input  wire logic               out_ready_i
);

  logic [escd_pkg::NumStages-1:0] vld_q, vld_d, en;

  always_comb begin
    en[escd_pkg::NumStages-1] = !vld_q[escd_pkg::NumStages-1] || out_ready_i;
    for (int k = escd_pkg::NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < escd_pkg::NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctrl_o.en  = en;
  assign ctrl_o.vld = vld_q;
  assign in_ready_o = en[0];

endmodule

`default_nettype wire

FILE: hdl/escd_civil.sv
// ----------------------------------------------------------------------------
// escd_civil: day count to proleptic Gregorian year, month and day
// Era split, day of era, year of era, day of year and month, spread over the
// stages from the era stage to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module escd_civil (
  input  wire logic                 clk_i,
  input  wire escd_pkg::pipe_ctrl_t ctrl_i,
  input  wire logic [22:0]          days_i,
  output logic [14:0]               year_o,
  output logic [3:0]                month_o,
  output logic [4:0]                day_o
);

  // era stage
  logic [22:0] z_d, z_q;
  logic [46:0] era_prod;
  logic [5:0]  era_d, era3_q;
  // day of era stage
  logic [22:0] doe_full;
  logic [17:0] doe_d, doe4_q;
  logic [5:0]  era4_q;
  // year of era argument stage
  logic [36:0] p1460;
  logic [6:0]  c1460;
  logic [2:0]  c36524;
  logic        c_last;
  logic [17:0] t_d, t_q, doe5_q;
  logic [5:0]  era5_q;
  // year of era stage
  logic [36:0] p365;
  logic [8:0]  yoe_d, yoe6_q;
  logic [17:0] doe6_q;
  logic [5:0]  era6_q;
  // day of year stage
  logic [18:0] p100;
  logic [2:0]  c100;
  logic [17:0] doy_base, doy_full;
  logic [8:0]  doy_d, doy7_q, yoe7_q;
  logic [5:0]  era7_q;
  // month stage
  logic [10:0] mp_arg;
  logic [22:0] p153;
  logic [3:0]  mp_d, mp_q;
  logic [8:0]  doy8_q, yoe8_q;
  logic [5:0]  era8_q;
  // output stage
  logic [10:0] d_arg;
  logic [22:0] p5;
  logic [8:0]  q5, dom_full;
  logic [3:0]  mon_d;
  logic [14:0] year_d, year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_d, day_q;

  always_comb begin
    z_d      = days_i + escd_pkg::DayShift;
    era_prod = 47'(z_d) * 47'(escd_pkg::RecipEra);
    era_d    = era_prod[46:41];

    doe_full = z_q - 23'(era3_q) * escd_pkg::DaysPerEra;
    doe_d    = doe_full[17:0];

    p1460  = 37'(doe4_q) * 37'(escd_pkg::Recip1460);
    c1460  = p1460[35:29];
    c36524 = 3'(doe4_q >= escd_pkg::DoeCent1) + 3'(doe4_q >= escd_pkg::DoeCent2)
           + 3'(doe4_q >= escd_pkg::DoeCent3) + 3'(doe4_q >= escd_pkg::DoeLast);
    c_last = (doe4_q == escd_pkg::DoeLast);
    t_d    = doe4_q - 18'(c1460) + 18'(c36524) - 18'(c_last);

    p365  = 37'(t_q) * 37'(escd_pkg::Recip365);
    yoe_d = p365[35:27];

    p100     = 19'(yoe6_q) * 19'(escd_pkg::Recip100);
    c100     = p100[18:16];
    doy_base = 18'(yoe6_q) * 18'd365 + 18'(yoe6_q[8:2]) - 18'(c100);
    doy_full = doe6_q - doy_base;
    doy_d    = doy_full[8:0];

    mp_arg = 11'(doy7_q) * 11'd5 + 11'd2;
    p153   = 23'(mp_arg) * 23'(escd_pkg::Recip153);
    mp_d   = p153[22:19];

    d_arg    = 11'(mp_q) * 11'd153 + 11'd2;
    p5       = 23'(d_arg) * 23'(escd_pkg::Recip5);
    q5       = p5[22:14];
    dom_full = doy8_q - q5 + 9'd1;
    day_d    = dom_full[4:0];
    // march-based month back to january-based
    mon_d    = (mp_q < 4'd10) ? mp_q + 4'd3 : mp_q - 4'd9;
    year_d   = 15'(yoe8_q) + 15'(era8_q) * 15'd400 + 15'(mon_d <= 4'd2);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[escd_pkg::StgEra]) begin
      z_q    <= z_d;
      era3_q <= era_d;
    end
    if (ctrl_i.en[escd_pkg::StgDoe]) begin
      doe4_q <= doe_d;
      era4_q <= era3_q;
    end
    if (ctrl_i.en[escd_pkg::StgYoeArg]) begin
      t_q    <= t_d;
      doe5_q <= doe4_q;
      era5_q <= era4_q;
    end
    if (ctrl_i.en[escd_pkg::StgYoe]) begin
      yoe6_q <= yoe_d;
      doe6_q <= doe5_q;
      era6_q <= era5_q;
    end
    if (ctrl_i.en[escd_pkg::StgDoy]) begin
      doy7_q <= doy_d;
      yoe7_q <= yoe6_q;
      era7_q <= era6_q;
    end
    if (ctrl_i.en[escd_pkg::StgMonth]) begin
      mp_q   <= mp_d;
      doy8_q <= doy7_q;
      yoe8_q <= yoe7_q;
      era8_q <= era7_q;
    end
    if (ctrl_i.en[escd_pkg::StgOut]) begin
      year_q  <= year_d;
      month_q <= mon_d;
      day_q   <= day_d;
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

`default_nettype wire

FILE: hdl/epoch_seconds_to_civil_datetime.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_datetime: unix seconds to civil date and time
// Subtracts the look-back window, clamps at the epoch and returns year,
// month, day, hour, minute and second of the resulting instant.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while the output side is ready, set by the ten-stage register pipeline
// each stage advances on its own, so a held output beat stalls only full stages
// reset: all stage valids clear and the window register returns to zero
// configuration port is always ready
`default_nettype none

module epoch_seconds_to_civil_datetime (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,     // window_seconds
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // now_seconds[39:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // year[14:0], month[18:15], day_of_month[23:19], hour[28:24],
  // minute[34:29], second[40:35], zero pad[47:41]
  output logic [47:0]      m_axis_tdata
);

  typedef struct packed {
    logic [4:0] hr;
    logic [5:0] mn;
    logic [5:0] sc;
  } hms_t;

  escd_pkg::pipe_ctrl_t ctrl;

  logic [31:0] win_q, win_d;

  // clamp stage
  logic [38:0] since_d, since_q;
  // quotient estimate stage
  logic [63:0] day_prod;
  logic [22:0] qe_d, qe_q;
  logic [31:0] x1_q;
  logic [escd_pkg::DayLoBits-1:0] lo1_q;
  // day fix stage
  logic [31:0] r32;
  logic [10:0] r11, rr;
  logic        fix;
  logic [22:0] days_d, days_q;
  logic [16:0] sod_d, sod_q;
  // hour, minute, second stages
  logic [34:0] p3600;
  logic [4:0]  hr3_d, hr3_q, hr4_q, hr5_q;
  logic [16:0] sod3_q, remh_full;
  logic [11:0] remh4_d, remh4_q, remh5_q;
  logic [24:0] p60;
  logic [5:0]  mn5_d, mn5_q;
  logic [11:0] sc_full;
  hms_t        hms6_d, hms6_q, hms7_q, hms8_q, hms9_q;

  logic [14:0] year;
  logic [3:0]  month;
  logic [4:0]  dom;

  escd_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .ctrl_o      (ctrl),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready)
  );

  assign cfg_ready_o = 1'b1;
  assign win_d       = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  always_comb begin
    // negative time or window past the epoch pins to zero
    if (s_axis_tdata[39] || (s_axis_tdata[38:0] <= 39'(win_q))) begin
      since_d = '0;
    end else begin
      since_d = s_axis_tdata[38:0] - 39'(win_q);
    end

    day_prod = 64'(since_q[38:escd_pkg::DayLoBits]) * 64'(escd_pkg::RecipDayHi);
    qe_d     = day_prod[63:41];

    r32    = x1_q - 32'(qe_q) * escd_pkg::DayHi;
    r11    = r32[10:0];
    fix    = (r11 >= 11'(escd_pkg::DayHi));
    days_d = fix ? qe_q + 23'd1 : qe_q;
    rr     = fix ? r11 - 11'(escd_pkg::DayHi) : r11;
    sod_d  = {rr[9:0], lo1_q};

    p3600 = 35'(sod_q) * 35'(escd_pkg::Recip3600);
    hr3_d = p3600[33:29];

    remh_full = sod3_q - 17'(hr3_q) * escd_pkg::SecsPerHour;
    remh4_d   = remh_full[11:0];

    p60   = 25'(remh4_q) * 25'(escd_pkg::Recip60);
    mn5_d = p60[23:18];

    sc_full   = remh5_q - 12'(mn5_q) * 12'd60;
    hms6_d.hr = hr5_q;
    hms6_d.mn = mn5_q;
    hms6_d.sc = sc_full[5:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[escd_pkg::StgClamp]) begin
      since_q <= since_d;
    end
    if (ctrl.en[escd_pkg::StgDivEst]) begin
      qe_q  <= qe_d;
      x1_q  <= since_q[38:escd_pkg::DayLoBits];
      lo1_q <= since_q[escd_pkg::DayLoBits-1:0];
    end
    if (ctrl.en[escd_pkg::StgDayFix]) begin
      days_q <= days_d;
      sod_q  <= sod_d;
    end
    if (ctrl.en[escd_pkg::StgEra]) begin
      hr3_q  <= hr3_d;
      sod3_q <= sod_q;
    end
    if (ctrl.en[escd_pkg::StgDoe]) begin
      remh4_q <= remh4_d;
      hr4_q   <= hr3_q;
    end
    if (ctrl.en[escd_pkg::StgYoeArg]) begin
      mn5_q   <= mn5_d;
      remh5_q <= remh4_q;
      hr5_q   <= hr4_q;
    end
    if (ctrl.en[escd_pkg::StgYoe]) begin
      hms6_q <= hms6_d;
    end
    if (ctrl.en[escd_pkg::StgDoy]) begin
      hms7_q <= hms6_q;
    end
    if (ctrl.en[escd_pkg::StgMonth]) begin
      hms8_q <= hms7_q;
    end
    if (ctrl.en[escd_pkg::StgOut]) begin
      hms9_q <= hms8_q;
    end
  end

  escd_civil u_civil (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .days_i  (days_q),
    .year_o  (year),
    .month_o (month),
    .day_o   (dom)
  );

  assign m_axis_tvalid = ctrl.vld[escd_pkg::StgOut];
  assign m_axis_tdata  = {7'd0, hms9_q.sc, hms9_q.mn, hms9_q.hr, dom, month, year};

endmodule

`default_nettype wire

FILE: hdl/escd_checker.sv
// ----------------------------------------------------------------------------
// escd_checker: port-level checks for the epoch to civil converter
// Tracks beats in flight and checks them against the stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module escd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);

  logic [escd_pkg::PendW-1:0] pend_q, pend_d;
  logic in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign pend_d  = pend_q + escd_pkg::PendW'(in_acc) - escd_pkg::PendW'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // never more beats in flight than register stages
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= escd_pkg::PendW'(escd_pkg::NumStages))
    else $error("more beats in flight than pipeline stages");

  // an output beat needs an input beat behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != '0)
    else $error("output beat with nothing in flight");

  // a free stage means the input side must be ready
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q < escd_pkg::PendW'(escd_pkg::NumStages) |-> s_axis_tready)
    else $error("input stalled with a free stage");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("held output beat changed");

endmodule

bind epoch_seconds_to_civil_datetime escd_checker u_escd_checker (.*);

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for epoch_seconds_to_civil_datetime
// Drives timestamps under several look-back windows, predicts each civil
// date and time in the bench and compares every output beat field by field.
// Both stream sides idle at random; window changes happen only once drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  // field order mirrors m_axis_tdata: year in the lowest bits
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [14:0] year;
  } civil_t;

  typedef struct {
    logic [31:0] win;
    logic [39:0] now;
    bit          typed;
    civil_t      civil;
  } stamp_row_t;

  localparam civil_t EpochCivil =
    '{year:15'd1970, month:4'd1, mday:5'd1, hour:5'd0, minute:6'd0, second:6'd0};

  localparam int NumPhases  = 6;
  localparam int PhaseItems = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  civil_t      pending_civil[$];
  logic [31:0] window;
  int          mismatches;
  int          stamps_sent;
  int          beats_checked;
  int          window_writes;
  bit          tx_steady;
  bit          rx_steady;

  // extremes, month and year edges, and the windows that reach past the epoch
  stamp_row_t stamp_table [24] = '{
    '{32'd0, 40'd0,             1'b1, EpochCivil},
    '{32'd0, 40'h80_0000_0000,  1'b1, EpochCivil},
    '{32'd0, 40'hFF_FFFF_FFFF,  1'b1, EpochCivil},
    '{32'd0, 40'hAA_AAAA_AAAA,  1'b1, EpochCivil},
    '{32'd0, 40'd86399,         1'b1,
      '{year:15'd1970, month:4'd1, mday:5'd1, hour:5'd23, minute:6'd59, second:6'd59}},
    '{32'd0, 40'd86400,         1'b1,
      '{year:15'd1970, month:4'd1, mday:5'd2, hour:5'd0, minute:6'd0, second:6'd0}},
    '{32'd0, 40'd2678400,       1'b1,
      '{year:15'd1970, month:4'd2, mday:5'd1, hour:5'd0, minute:6'd0, second:6'd0}},
    '{32'd0, 40'd31535999,      1'b1,
      '{year:15'd1970, month:4'd12, mday:5'd31, hour:5'd23, minute:6'd59, second:6'd59}},
    '{32'd0, 40'd946684799,     1'b0, '0},
    '{32'd0, 40'd951782400,     1'b0, '0},
    '{32'd0, 40'd951868799,     1'b0, '0},
    '{32'd0, 40'd4107542400,    1'b0, '0},
    '{32'd0, 40'h55_5555_5555,  1'b0, '0},
    '{32'd0, 40'h7F_FFFF_FFFF,  1'b0, '0},
    '{32'hFFFF_FFFF, 40'h00_FFFF_FFFF, 1'b1, EpochCivil},
    '{32'hFFFF_FFFF, 40'h01_0000_0000, 1'b1,
      '{year:15'd1970, month:4'd1, mday:5'd1, hour:5'd0, minute:6'd0, second:6'd1}},
    '{32'hFFFF_FFFF, 40'h01_0001_517F, 1'b1,
      '{year:15'd1970, month:4'd1, mday:5'd2, hour:5'd0, minute:6'd0, second:6'd0}},
    '{32'hFFFF_FFFF, 40'd5,            1'b1, EpochCivil},
    '{32'hFFFF_FFFF, 40'h7F_FFFF_FFFF, 1'b0, '0},
    '{32'hFFFF_FFFF, 40'h80_0000_0000, 1'b1, EpochCivil},
    '{32'd3600, 40'd3600,              1'b1, EpochCivil},
    '{32'd3600, 40'd3601,              1'b1,
      '{year:15'd1970, month:4'd1, mday:5'd1, hour:5'd0, minute:6'd0, second:6'd1}},
    '{32'd3600, 40'd10799,             1'b1,
      '{year:15'd1970, month:4'd1, mday:5'd1, hour:5'd1, minute:6'd59, second:6'd59}},
    '{32'd3600, 40'h12_3456_789A,      1'b0, '0}
  };

  epoch_seconds_to_civil_datetime dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // civil date and time of (now - win), clamped at the epoch
  function automatic civil_t civil_of_lookback(input logic [39:0] now,
                                               input logic [31:0] win);
    longint unsigned since, days, sod, z, era, doe, yoe, doy, mp, mo;
    civil_t c;
    since = longint'(now[38:0]);
    if (now[39] || since <= longint'(win)) begin
      since = 0;
    end else begin
      since = since - longint'(win);
    end
    days = since / 86400;
    sod  = since % 86400;
    // shift to a march-based year counted from 0000-03-01
    z   = days + 719468;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    mo  = (mp < 10) ? mp + 3 : mp - 9;
    c.mday   = 5'(doy - (153 * mp + 2) / 5 + 1);
    c.month  = 4'(mo);
    c.year   = 15'(yoe + era * 400 + ((mo <= 2) ? 1 : 0));
    c.hour   = 5'(sod / 3600);
    c.minute = 6'((sod % 3600) / 60);
    c.second = 6'(sod % 60);
    return c;
  endfunction

  // mostly timestamps that land past the window, with day, leap and
  // century edges, plus negative and full-range noise
  function automatic logic [39:0] pick_stamp(input logic [31:0] win);
    longint unsigned base, t, days;
    base = longint'(win);
    case ($urandom_range(0, 7))
      0: t = {$urandom, $urandom};
      1: t = {$urandom, $urandom} | (64'd1 << 39);
      2: t = base + $urandom_range(0, 4) - 2;
      3: t = base + $urandom;
      4: begin
        days = longint'($urandom_range(0, 6000000));
        t = base + days * 86400 + ($urandom_range(0, 1) ? 86399 : 0);
      end
      5: t = {$urandom, $urandom} & ((64'd1 << 39) - 1);
      6: begin
        // around the first of march in a leap or a century year
        days = 11017 + longint'($urandom_range(0, 3)) * 36524
             + longint'($urandom_range(0, 40)) * 146097;
        days = days + $urandom_range(0, 4) - 2;
        t = base + days * 86400 + $urandom_range(0, 86399);
      end
      default: t = base + $urandom_range(0, 200000);
    endcase
    return t[39:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at beat %0d: %s", beats_checked, msg);
    end
  endtask

  task automatic send_stamp(input logic [39:0] now, input civil_t want);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_civil.push_back(want);
    stamps_sent++;
  endtask

  // drain everything in flight, then write the look-back window
  task automatic set_window(input logic [31:0] win);
    s_axis_tvalid <= 1'b0;
    while (pending_civil.size() != 0) @(posedge clk_i);
    repeat (escd_pkg::NumStages) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= win;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    window = win;
    window_writes++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAIL epoch_seconds_to_civil_datetime");
    $finish;
  end

  // result side: random stalls, each beat checked against the oldest expectation
  initial begin
    int gap;
    civil_t got;
    civil_t want;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = civil_t'(m_axis_tdata[40:0]);
      if (pending_civil.size() == 0) begin
        report_mismatch("output beat with nothing expected");
      end else begin
        want = pending_civil.pop_front();
        if (got.year != want.year)
          report_mismatch($sformatf("year %0d, expected %0d", got.year, want.year));
        if (got.month != want.month)
          report_mismatch($sformatf("month %0d, expected %0d", got.month, want.month));
        if (got.mday != want.mday)
          report_mismatch($sformatf("day %0d, expected %0d", got.mday, want.mday));
        if (got.hour != want.hour)
          report_mismatch($sformatf("hour %0d, expected %0d", got.hour, want.hour));
        if (got.minute != want.minute)
          report_mismatch($sformatf("minute %0d, expected %0d", got.minute, want.minute));
        if (got.second != want.second)
          report_mismatch($sformatf("second %0d, expected %0d", got.second, want.second));
      end
      beats_checked++;
    end
  end

  initial begin
    logic [31:0] phase_win [NumPhases];
    logic [39:0] now;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // window starts at its reset value of zero
    window = '0;

    foreach (stamp_table[i]) begin
      if (stamp_table[i].win != window) set_window(stamp_table[i].win);
      send_stamp(stamp_table[i].now,
                 stamp_table[i].typed ? stamp_table[i].civil
                                      : civil_of_lookback(stamp_table[i].now, window));
    end

    phase_win[0] = 32'd0;
    phase_win[1] = 32'hFFFF_FFFF;
    phase_win[2] = 32'd1;
    phase_win[3] = 32'd86400;
    phase_win[4] = $urandom;
    phase_win[5] = $urandom;
    for (int p = 0; p < NumPhases; p++) begin
      set_window(phase_win[p]);
      for (int i = 0; i < PhaseItems; i++) begin
        now = pick_stamp(window);
        send_stamp(now, civil_of_lookback(now, window));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_civil.size() != 0) @(posedge clk_i);
    repeat (2 * escd_pkg::NumStages) @(posedge clk_i);

    $display("run covered %0d timestamps under %0d window writes", stamps_sent, window_writes);
    $display("%0d result beats checked, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS epoch_seconds_to_civil_datetime");
    end else begin
      $display("FAIL epoch_seconds_to_civil_datetime");
    end
    $finish;
  end

endmodule

`default_nettype wire
